// ----- design/ipt_pkg.sv -----
// shared types and constants for the ipv6 prefix table lookup unit
package ipt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);

   localparam int ADDR_W        = 128;
   localparam int HALF_W        = 64;
   localparam int LEN_W         = 8;
   localparam int OPCODE_W      = 2;
   localparam int REQ_DATA_W    = 2 * HALF_W + LEN_W;
   localparam int RSP_DATA_W    = 16;

   localparam logic [LEN_W-1:0] FULL_LENGTH = 8'd128;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } ipt_op_type;

   typedef enum logic [1:0] {
      IPT_IDLE,
      IPT_SCAN,
      IPT_RESP
   } ipt_state_type;

   typedef struct packed {
      logic [HALF_W-1:0] prefix_high;
      logic [HALF_W-1:0] prefix_low;
      logic [LEN_W-1:0]  length;
   } ipt_entry_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      ipt_entry_type     data;
   } ipt_wr_type;

   // op_status in bit 0, found in bit 1, matched_length above
   typedef struct packed {
      logic [LEN_W-1:0] matched_length;
      logic             found;
      logic             op_status;
   } ipt_result_type;

   localparam int RESULT_W = $bits(ipt_result_type);

endpackage

// ----- design/ipt_table_ram.sv -----
// prefix table storage: one write port, one registered read port
module ipt_table_ram (
   input  logic                  clock,
   input  ipt_pkg::ipt_wr_type   wr,
   input  logic [ipt_pkg::IDX_W-1:0] rd_addr,
   output ipt_pkg::ipt_entry_type    rd_data
);
   import ipt_pkg::*;

   ipt_entry_type mem [TABLE_ENTRIES];
   ipt_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ipt_match.sv -----
// masked prefix compare of one table entry against the lookup address
module ipt_match (
   input  ipt_pkg::ipt_entry_type       entry,
   input  logic [ipt_pkg::ADDR_W-1:0]   key,
   output logic                         hit
);
   import ipt_pkg::*;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < ADDR_W; i++) begin
         mask[ADDR_W-1-i] = (LEN_W'(i) < len);
      end
      return mask;
   endfunction

   logic [ADDR_W-1:0] mask;
   logic [ADDR_W-1:0] diff;

   assign mask = prefix_mask(entry.length);
   assign diff = key ^ {entry.prefix_high, entry.prefix_low};
   assign hit  = ((diff & mask) == '0);

endmodule

// ----- design/ipv6_prefix_table_lookup_unit.sv -----
// ipv6 prefix table with first-hit lookup, top level
// add, clear and unused opcodes: the result goes through IPT_RESP to the output register
// lookup: one table read per cycle in IPT_SCAN up to the first hit or past the last entry,
//   then the result goes through IPT_RESP, which waits for the output register to be free
// one request in flight; the next is taken once the result sits in the output register
// synchronous reset empties the table count and drops any pending result
module ipv6_prefix_table_lookup_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ipt_pkg::REQ_DATA_W-1:0]  req_tdata,  // addr_high, addr_low, prefix_length
   input  logic [ipt_pkg::OPCODE_W-1:0]    req_tuser,  // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ipt_pkg::RSP_DATA_W-1:0]  rsp_tdata   // op_status, found, matched_length
);
   import ipt_pkg::*;

   ipt_state_type         state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]     key_ff, key_in;
   ipt_result_type        res_ff, res_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   ipt_result_type        rsp_data_ff, rsp_data_in;

   ipt_wr_type            wr;
   ipt_entry_type         rd_entry;
   logic                  hit;
   logic                  accept;
   logic                  issue;
   logic                  out_free;
   ipt_op_type            opcode;
   logic [HALF_W-1:0]     in_high;
   logic [HALF_W-1:0]     in_low;
   logic [LEN_W-1:0]      in_len;

   assign opcode  = ipt_op_type'(req_tuser);
   assign in_high = req_tdata[HALF_W-1:0];
   assign in_low  = req_tdata[2*HALF_W-1:HALF_W];
   assign in_len  = req_tdata[REQ_DATA_W-1:2*HALF_W];

   assign accept   = req_tvalid && req_tready;
   assign issue    = (rd_idx_ff < count_ff);
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   ipt_table_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   ipt_match u_match (
      .entry (rd_entry),
      .key   (key_ff),
      .hit   (hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IPT_IDLE: begin
            if (accept) begin
               state_in = (opcode == OP_LOOKUP) ? IPT_SCAN : IPT_RESP;
            end
         end
         IPT_SCAN: begin
            if ((cmp_vld_ff && hit) || (!issue && !cmp_vld_ff)) begin
               state_in = IPT_RESP;
            end
         end
         IPT_RESP: begin
            if (out_free) begin
               state_in = IPT_IDLE;
            end
         end
         default: state_in = IPT_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready    = (state_ff == IPT_IDLE) && !reset;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = 1'b0;
      key_in        = key_ff;
      res_in        = res_ff;
      wr            = '0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         IPT_IDLE: begin
            if (accept) begin
               res_in = '0;
               case (opcode)
                  OP_LOOKUP: begin
                     key_in    = {in_high, in_low};
                     rd_idx_in = '0;
                  end
                  OP_ADD: begin
                     if (count_ff < COUNT_W'(TABLE_ENTRIES)) begin
                        wr.en               = 1'b1;
                        wr.addr             = count_ff[IDX_W-1:0];
                        wr.data.prefix_high = in_high;
                        wr.data.prefix_low  = in_low;
                        wr.data.length      = (in_len > FULL_LENGTH) ? FULL_LENGTH : in_len;
                        count_in            = count_ff + COUNT_W'(1);
                     end else begin
                        res_in.op_status = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         IPT_SCAN: begin
            rd_idx_in  = rd_idx_ff + COUNT_W'(issue);
            cmp_vld_in = issue;
            if (cmp_vld_ff && hit) begin
               res_in.found          = 1'b1;
               res_in.matched_length = rd_entry.length;
               cmp_vld_in            = 1'b0;
            end
         end
         IPT_RESP: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = res_ff;
            end
         end
         default: begin
            cmp_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IPT_IDLE;
         count_ff      <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RESULT_W){1'b0}}, rsp_data_ff};

endmodule

// ----- design/ipt_checker.sv -----
// port-level checks for the ipv6 prefix table lookup unit, with bind
module ipt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ipt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ipt_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a hit never carries a rejected status
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("found together with op_status");

   // a miss reports length zero, a hit at most the full length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> (rsp_tdata[9:2] == '0))
      else $error("nonzero length without a hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> (rsp_tdata[9:2] <= FULL_LENGTH))
      else $error("matched length above full length");

   // one request in flight: ready drops after a request transaction
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

endmodule

bind ipv6_prefix_table_lookup_unit ipt_checker u_ipt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_ipv6_prefix_table_lookup_unit.sv -----
// self-checking testbench for the ipv6 prefix table lookup unit
module tb_ipv6_prefix_table_lookup_unit;
   import ipt_pkg::*;

   class prefix_table_scoreboard;
      logic [ADDR_W-1:0] prefix_store [TABLE_ENTRIES];
      logic [LEN_W-1:0]  length_store [TABLE_ENTRIES];
      int unsigned       entry_total;
      ipt_result_type    expected_results [$];
      int                mismatch_count;

      function new();
         entry_total    = 0;
         mismatch_count = 0;
      endfunction

      function logic [ADDR_W-1:0] prefix_mask(logic [LEN_W-1:0] len);
         if (len == 0) return '0;
         return ~{ADDR_W{1'b0}} << (ADDR_W - len);
      endfunction

      function ipt_result_type predict_result(ipt_op_type op, logic [ADDR_W-1:0] addr,
                                              logic [LEN_W-1:0] len);
         ipt_result_type res;
         logic [ADDR_W-1:0] m;
         res = '0;
         case (op)
            OP_LOOKUP: begin
               for (int i = 0; i < entry_total; i++) begin
                  m = prefix_mask(length_store[i]);
                  if ((addr & m) == (prefix_store[i] & m)) begin
                     res.found          = 1'b1;
                     res.matched_length = length_store[i];
                     break;
                  end
               end
            end
            OP_ADD: begin
               if (entry_total >= TABLE_ENTRIES) begin
                  res.op_status = 1'b1;
               end else begin
                  prefix_store[entry_total] = addr;
                  length_store[entry_total] = (len > FULL_LENGTH) ? FULL_LENGTH : len;
                  entry_total++;
               end
            end
            OP_CLEAR: entry_total = 0;
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(ipt_op_type op, logic [ADDR_W-1:0] addr,
                                 logic [LEN_W-1:0] len);
         expected_results.push_back(predict_result(op, addr, len));
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         ipt_result_type got;
         ipt_result_type want;
         got = data[RESULT_W-1:0];
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response transaction: data %h", data);
            return;
         end
         want = expected_results.pop_front();
         if (got.op_status !== want.op_status || got.found !== want.found ||
             got.matched_length !== want.matched_length) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: op_status %0d/%0d found %0d/%0d length %0d/%0d (exp/act)",
                        want.op_status, got.op_status, want.found, got.found,
                        want.matched_length, got.matched_length);
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OPCODE_W-1:0]   req_tuser  = OP_NONE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic                  hold_rsp      = 1'b0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;

   prefix_table_scoreboard sb = new();

   ipv6_prefix_table_lookup_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= hold_rsp ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   task automatic send_request(ipt_op_type op, logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo,
                               logic [LEN_W-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {len, lo, hi};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_request(op, {hi, lo}, len);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sb.expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic hold_responses(int cycles);
      hold_rsp <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_rsp <= 1'b0;
   endtask

   task automatic send_random_item();
      int unsigned       pick;
      int unsigned       idx;
      int unsigned       bitpos;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] m;
      logic [LEN_W-1:0]  len;
      ipt_op_type        op;
      pick = $urandom_range(99);
      addr = {$urandom, $urandom, $urandom, $urandom};
      len  = LEN_W'($urandom);
      if (pick < 4) begin
         op = OP_CLEAR;
      end else if (pick < 7) begin
         op = OP_NONE;
      end else if (pick < 42) begin
         op = OP_ADD;
         case ($urandom_range(3))
            0: ;
            1: begin
               if (sb.entry_total > 0) begin
                  // prefix no longer than an existing entry, covering it
                  idx  = $urandom_range(sb.entry_total - 1);
                  m    = sb.prefix_mask(sb.length_store[idx]);
                  addr = (sb.prefix_store[idx] & m) | (addr & ~m);
                  len  = LEN_W'($urandom_range(sb.length_store[idx]));
               end
            end
            default: len = LEN_W'($urandom_range(FULL_LENGTH));
         endcase
      end else begin
         op = OP_LOOKUP;
         if (sb.entry_total > 0 && $urandom_range(9) < 7) begin
            idx  = $urandom_range(sb.entry_total - 1);
            m    = sb.prefix_mask(sb.length_store[idx]);
            addr = (sb.prefix_store[idx] & m) | (addr & ~m);
            if (sb.length_store[idx] > 0 && $urandom_range(2) == 0) begin
               bitpos = $urandom_range(sb.length_store[idx] - 1);
               addr[ADDR_W-1-bitpos] = ~addr[ADDR_W-1-bitpos];
            end
         end
      end
      send_request(op, addr[ADDR_W-1:HALF_W], addr[HALF_W-1:0], len);
   endtask

   initial begin
      #2_000_000;
      $display("tb_ipv6_prefix_table_lookup_unit: done, errors");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_request(OP_LOOKUP, '1, '1, 8'hff);
      send_request(OP_NONE, '1, '1, 8'hff);
      send_request(OP_ADD, 64'h2001_0db8_0000_0000, '0, 8'd32);
      send_request(OP_ADD, '1, '1, 8'd128);
      send_request(OP_ADD, '0, '0, 8'd255);
      send_request(OP_ADD, 64'hfe80_0000_0000_0000, '0, 8'd64);
      send_request(OP_ADD, 64'h3fff_0000_aaaa_5555, 64'h8000_0000_0000_0000, 8'd65);
      send_request(OP_LOOKUP, 64'h2001_0db8_ffff_ffff, 64'h0123_4567_89ab_cdef, 8'd0);
      send_request(OP_LOOKUP, '1, '1, 8'd0);
      send_request(OP_LOOKUP, '0, '0, 8'd0);
      send_request(OP_LOOKUP, 64'hfe80_0000_0000_0000, '1, 8'd0);
      send_request(OP_LOOKUP, 64'h3fff_0000_aaaa_5555, 64'h8fff_ffff_ffff_ffff, 8'd0);
      send_request(OP_LOOKUP, 64'h3fff_0000_aaaa_5555, 64'h7fff_ffff_ffff_ffff, 8'd0);
      for (int i = 0; i < TABLE_ENTRIES - 5; i++)
         send_request(OP_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 8'(i * 12 + 1));
      send_request(OP_ADD, '1, '1, 8'd0);
      send_request(OP_LOOKUP, {$urandom, $urandom}, {$urandom, $urandom}, 8'd0);
      send_request(OP_CLEAR, '1, '1, 8'hff);
      send_request(OP_LOOKUP, '1, '1, 8'd0);
      drain_responses();

      // random phases with different idle mixes
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               fork
                  hold_responses(300);
               join_none
            end
         endcase
         for (int n = 0; n < 134; n++)
            send_random_item();
         drain_responses();
      end

      repeat (30) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
         $display("tb_ipv6_prefix_table_lookup_unit: done, clean");
      end else begin
         $display("tb_ipv6_prefix_table_lookup_unit: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ipt_pkg.sv
design/ipt_table_ram.sv
design/ipt_match.sv
design/ipv6_prefix_table_lookup_unit.sv
design/ipt_checker.sv
bench/tb_ipv6_prefix_table_lookup_unit.sv
